>>> rtl/core/ydw_pkg.sv
// Package for the weighted Young diagram growth block.
// Holds sizes, payload word types and the weight unit request/response structs.
// Depends on nothing.
package ydw_pkg;

  localparam int MAX_COLUMNS = 256;
  localparam int HEIGHT_BITS = 12;
  localparam int RND_W       = 64;
  localparam int OUT_W       = 9;
  localparam int ALPHA_W     = 2;

  // weight pipeline depth, in stages from request to response
  localparam int WLAT    = 3;
  // column index, able to hold MAX_COLUMNS itself
  localparam int CNT_W   = $clog2(MAX_COLUMNS + 1);
  // scan step counter, covers the drain of the weight pipeline
  localparam int STEP_W  = $clog2(MAX_COLUMNS + WLAT + 1);
  // perimeter 2*(x+h+2)
  localparam int P_W     = $clog2(2 * (MAX_COLUMNS + (1 << HEIGHT_BITS) + 1) + 1);
  localparam int SQ_W    = 2 * P_W;
  localparam int W_W     = 3 * P_W;
  localparam int SUM_W   = W_W + CNT_W;
  localparam int RND_CW  = $clog2(RND_W + 1);

  localparam logic [HEIGHT_BITS-1:0] HEIGHT_MAX = {HEIGHT_BITS{1'b1}};

  localparam logic ACT_CLEAR = 1'b0;
  localparam logic ACT_GROW  = 1'b1;

  typedef struct packed {
    logic             action;
    logic [RND_W-1:0] random_word;
  } cmd_t;

  typedef struct packed {
    logic [OUT_W-1:0] chosen_column;
    logic [OUT_W-1:0] column_count;
    logic             saturated;
  } res_t;

  typedef struct packed {
    logic                   valid;
    logic                   cand;
    logic [CNT_W-1:0]       x;
    logic [HEIGHT_BITS-1:0] h;
  } wgt_req_t;

  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] x;
    logic [W_W-1:0]   w;
  } wgt_rsp_t;

endpackage

>>> rtl/core/ydw_cell.sv
// One column cell of the height chain: holds one column height.
// Shifts toward the head when told; loads its cleared value on clear.
// Depends on ydw_pkg.
module ydw_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            clear_i,
  input  logic                            shift_i,
  input  logic                            init_one_i,
  input  logic [ydw_pkg::HEIGHT_BITS-1:0] h_i,
  output logic [ydw_pkg::HEIGHT_BITS-1:0] h_o
);

  logic [ydw_pkg::HEIGHT_BITS-1:0] h_d, h_q;

  // load cleared value, take neighbor's height, or hold
  always_comb begin
    h_d = h_q;
    if (clear_i) begin
      h_d = {{(ydw_pkg::HEIGHT_BITS-1){1'b0}}, init_one_i};
    end else if (shift_i) begin
      h_d = h_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= '0;
    end else begin
      h_q <= h_d;
    end
  end

  assign h_o = h_q;

endmodule

>>> rtl/core/ydw_weight.sv
// Three-stage weight pipeline: (2*(x+h+2))^alpha, zero for non-candidates.
// Depends on ydw_pkg.
module ydw_weight (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [ydw_pkg::ALPHA_W-1:0] alpha_i,
  input  ydw_pkg::wgt_req_t           req_i,
  output ydw_pkg::wgt_rsp_t           rsp_o
);

  logic                      v1_q, v2_q, v3_q;
  logic                      c1_q, c2_q;
  logic [ydw_pkg::CNT_W-1:0] x1_q, x2_q, x3_q;
  logic [ydw_pkg::P_W-1:0]   p1_q, p2_q;
  logic [ydw_pkg::SQ_W-1:0]  sq2_q;
  logic [ydw_pkg::W_W-1:0]   w3_q;
  logic [ydw_pkg::P_W-1:0]   p_d;
  logic [ydw_pkg::SQ_W-1:0]  sq_d;
  logic [ydw_pkg::W_W-1:0]   w_d;

  // perimeter
  assign p_d = ydw_pkg::P_W'({(ydw_pkg::P_W)'(req_i.x) + (ydw_pkg::P_W)'(req_i.h)
                + (ydw_pkg::P_W)'(2), 1'b0});

  // square
  assign sq_d = (ydw_pkg::SQ_W)'(p1_q) * (ydw_pkg::SQ_W)'(p1_q);

  // pick the power, drop non-candidates
  always_comb begin
    case (alpha_i)
      2'd0:    w_d = (ydw_pkg::W_W)'(1);
      2'd1:    w_d = (ydw_pkg::W_W)'(p2_q);
      2'd2:    w_d = (ydw_pkg::W_W)'(sq2_q);
      default: w_d = (ydw_pkg::W_W)'(sq2_q) * (ydw_pkg::W_W)'(p2_q);
    endcase
    if (!c2_q) begin
      w_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= req_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c1_q  <= req_i.cand;
    x1_q  <= req_i.x;
    p1_q  <= p_d;
    c2_q  <= c1_q;
    x2_q  <= x1_q;
    p2_q  <= p1_q;
    sq2_q <= sq_d;
    x3_q  <= x2_q;
    w3_q  <= w_d;
  end

  assign rsp_o.valid = v3_q;
  assign rsp_o.x     = x3_q;
  assign rsp_o.w     = w3_q;

endmodule

>>> rtl/core/ydw_modulo.sv
// Restoring remainder unit: one dividend bit per cycle.
// Depends on ydw_pkg.
module ydw_modulo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ydw_pkg::RND_W-1:0] dividend_i,
  input  logic [ydw_pkg::SUM_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [ydw_pkg::SUM_W-1:0] rem_o
);

  logic                       busy_q, done_q;
  logic [ydw_pkg::RND_CW-1:0] cnt_q;
  logic [ydw_pkg::RND_W-1:0]  num_q;
  logic [ydw_pkg::SUM_W-1:0]  den_q, rem_q;
  logic [ydw_pkg::SUM_W:0]    trial;

  // shift in next bit, subtract when it fits
  assign trial = {rem_q, num_q[ydw_pkg::RND_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == (ydw_pkg::RND_CW)'(ydw_pkg::RND_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[ydw_pkg::RND_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_q <= ydw_pkg::SUM_W'(trial - {1'b0, den_q});
      end else begin
        rem_q <= ydw_pkg::SUM_W'(trial);
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

>>> rtl/core/young_diagram_weighted_growth.sv
// Weighted Young diagram growth, top level: column cell chain, weight pipeline, remainder unit.
// Clear word: result in the cycle after acceptance. Grow word: result after a summing scan
// rotation, a 64-step remainder, a picking scan rotation and an update rotation of the chain.
// One word in flight: the next word is taken as its result leaves; the receiver cannot stall.
// After reset the block loads the single-cell diagram in its init state (busy), then goes idle.
module young_diagram_weighted_growth (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  ydw_pkg::cmd_t               cmd_i,
  output logic                        done_o,
  output ydw_pkg::res_t               res_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ydw_pkg::ALPHA_W-1:0] cfg_data_i
);

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SUM   = 6'b000100,
    S_MOD   = 6'b001000,
    S_PICK  = 6'b010000,
    S_APPLY = 6'b100000
  } state_e;

  localparam int NC = ydw_pkg::MAX_COLUMNS;
  localparam int HB = ydw_pkg::HEIGHT_BITS;
  localparam logic [ydw_pkg::STEP_W-1:0] LAST_STEP =
    (ydw_pkg::STEP_W)'(ydw_pkg::MAX_COLUMNS + ydw_pkg::WLAT);
  localparam logic [ydw_pkg::STEP_W-1:0] NC_STEP = (ydw_pkg::STEP_W)'(NC);
  localparam logic [ydw_pkg::CNT_W-1:0]  NC_CNT  = (ydw_pkg::CNT_W)'(NC);

  state_e                         state_d, state_q;
  logic [ydw_pkg::STEP_W-1:0]     cnt_d, cnt_q;
  logic [ydw_pkg::CNT_W-1:0]      used_d, used_q, chosen_d, chosen_q;
  logic [ydw_pkg::SUM_W-1:0]      total_d, total_q, run_d, run_q, target_d, target_q;
  logic                           found_d, found_q, sat_d, sat_q, go_d, go_q;
  logic                           done_d, done_q;
  logic [ydw_pkg::RND_W-1:0]      rnd_d, rnd_q;
  logic [HB-1:0]                  prev_q;
  logic [ydw_pkg::ALPHA_W-1:0]    alpha_q;
  ydw_pkg::res_t                  res_d, res_q;

  logic [HB-1:0]                  heights [NC];
  logic [HB-1:0]                  head, wrap, cur;
  logic                           clear, shift, scan, accept;
  logic [ydw_pkg::CNT_W-1:0]      x;
  logic                           is_new;
  ydw_pkg::wgt_req_t              req;
  ydw_pkg::wgt_rsp_t              rsp;
  logic                           div_done;
  logic [ydw_pkg::SUM_W-1:0]      rem;
  logic [ydw_pkg::SUM_W-1:0]      run_next;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign head        = heights[0];
  assign scan        = (state_q == S_SUM || state_q == S_PICK) && (cnt_q <= NC_STEP);
  assign shift       = ((state_q == S_SUM || state_q == S_PICK) && (cnt_q < NC_STEP))
                       || (state_q == S_APPLY);
  assign clear       = (state_q == S_INIT) || (accept && cmd_i.action == ydw_pkg::ACT_CLEAR);
  assign x           = ydw_pkg::CNT_W'(cnt_q);
  assign is_new      = (x == used_q);
  assign cur         = (cnt_q < NC_STEP) ? head : '0;

  // column chain, rotating toward the head
  for (genvar k = 0; k < NC; k++) begin : g_cell
    logic [HB-1:0] nb;
    if (k == NC - 1) begin : g_tail
      assign nb = wrap;
    end else begin : g_mid
      assign nb = heights[k+1];
    end
    ydw_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .clear_i    (clear),
      .shift_i    (shift),
      .init_one_i (k == 0),
      .h_i        (nb),
      .h_o        (heights[k])
    );
  end

  // candidate request for the column at the head
  always_comb begin
    req.valid = scan;
    req.x     = x;
    req.cand  = (x == '0) || is_new || ((x < used_q) && (prev_q > cur));
    if (x == '0) begin
      req.h = cur;
    end else if (is_new) begin
      req.h = '0;
    end else begin
      req.h = prev_q;
    end
  end

  ydw_weight u_weight (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .alpha_i (alpha_q),
    .req_i   (req),
    .rsp_o   (rsp)
  );

  ydw_modulo u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (go_q),
    .dividend_i (rnd_q),
    .divisor_i  (total_q),
    .done_o     (div_done),
    .rem_o      (rem)
  );

  assign run_next = run_q + (ydw_pkg::SUM_W)'(rsp.w);

  // sequencer and in-flight update of the wrapping height
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    used_d   = used_q;
    chosen_d = chosen_q;
    total_d  = total_q;
    run_d    = run_q;
    target_d = target_q;
    found_d  = found_q;
    sat_d    = sat_q;
    go_d     = 1'b0;
    done_d   = 1'b0;
    rnd_d    = rnd_q;
    res_d    = res_q;
    wrap     = head;
    case (state_q)
      S_INIT: begin
        used_d  = (ydw_pkg::CNT_W)'(1);
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (cmd_i.action == ydw_pkg::ACT_CLEAR) begin
            used_d              = (ydw_pkg::CNT_W)'(1);
            res_d.chosen_column = '0;
            res_d.column_count  = (ydw_pkg::OUT_W)'(1);
            res_d.saturated     = 1'b0;
            done_d              = 1'b1;
          end else begin
            rnd_d   = cmd_i.random_word;
            cnt_d   = '0;
            total_d = '0;
            state_d = S_SUM;
          end
        end
      end
      S_SUM: begin
        if (rsp.valid) begin
          total_d = total_q + (ydw_pkg::SUM_W)'(rsp.w);
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          go_d    = 1'b1;
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        if (div_done) begin
          target_d = rem;
          cnt_d    = '0;
          run_d    = '0;
          found_d  = 1'b0;
          chosen_d = used_q;
          state_d  = S_PICK;
        end
      end
      S_PICK: begin
        if (rsp.valid && !found_q) begin
          run_d = run_next;
          if (run_next > target_q) begin
            found_d  = 1'b1;
            chosen_d = rsp.x;
          end
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          cnt_d   = '0;
          sat_d   = 1'b0;
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        if (cnt_q == '0 && chosen_q == used_q && used_q == NC_CNT) begin
          sat_d = 1'b1;
        end
        if (x == chosen_q) begin
          if (chosen_q < used_q) begin
            if (head == ydw_pkg::HEIGHT_MAX) begin
              sat_d = 1'b1;
            end else begin
              wrap = head + 1'b1;
            end
          end else if (used_q < NC_CNT) begin
            wrap   = (HB)'(1);
            used_d = used_q + 1'b1;
          end
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == NC_STEP - 1'b1) begin
          res_d.chosen_column = (ydw_pkg::OUT_W)'(chosen_q);
          res_d.column_count  = (ydw_pkg::OUT_W)'(used_d);
          res_d.saturated     = sat_d;
          done_d              = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      cnt_q   <= '0;
      used_q  <= (ydw_pkg::CNT_W)'(1);
      found_q <= 1'b0;
      go_q    <= 1'b0;
      done_q  <= 1'b0;
      alpha_q <= (ydw_pkg::ALPHA_W)'(1);
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      used_q  <= used_d;
      found_q <= found_d;
      go_q    <= go_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        alpha_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    chosen_q <= chosen_d;
    total_q  <= total_d;
    run_q    <= run_d;
    target_q <= target_d;
    sat_q    <= sat_d;
    rnd_q    <= rnd_d;
    res_q    <= res_d;
    if (shift) begin
      prev_q <= head;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // an accepted word keeps the block busy or finishes at once
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy || done_o))
    else $error("accepted word neither in progress nor finished");

  // column count stays within the store
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.column_count != '0 &&
                res_o.column_count <= (ydw_pkg::OUT_W)'(NC)))
    else $error("column count out of range");

  // the chosen column lies within the candidates
  a_chosen_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.chosen_column <= res_o.column_count))
    else $error("chosen column beyond last candidate");

  // the remainder never reaches the total
  a_target_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PICK) |-> (target_q < total_q))
    else $error("target not below total weight");

endmodule

>>> bench/young_diagram_weighted_growth_test.sv
// Testbench for the weighted Young diagram growth block.
// Drives clear and grow words, predicts each result and checks it as it arrives.
// Depends on ydw_pkg and the young_diagram_weighted_growth RTL.
module young_diagram_weighted_growth_test;

  localparam int LIMIT = 20_000_000;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start;
  logic                        busy;
  ydw_pkg::cmd_t               cmd_i;
  logic                        done_o;
  ydw_pkg::res_t               res_o;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic [ydw_pkg::ALPHA_W-1:0] cfg_data_i;

  young_diagram_weighted_growth u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Shadow diagram used to predict results
  logic [ydw_pkg::HEIGHT_BITS-1:0] shadow_heights [ydw_pkg::MAX_COLUMNS];
  int                              shadow_used;
  logic [ydw_pkg::ALPHA_W-1:0]     shadow_alpha;

  ydw_pkg::res_t pending_results [$];
  int            error_count;
  int            cycle_count;
  int            word_count;
  int            sat_count;
  int            idle_pct;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("%0t timeout with %0d results pending", $time, pending_results.size());
      $display("young_diagram_weighted_growth_test: errors");
      $finish;
    end
  end

  // Weight of one candidate column, zero if it cannot take a cell
  function automatic logic [63:0] column_weight(int x);
    logic [63:0] perim;
    logic [63:0] w;
    int          hh;
    if (x == 0) hh = shadow_heights[0];
    else if (x == shadow_used) hh = 0;
    else if (shadow_heights[x-1] > shadow_heights[x]) hh = shadow_heights[x-1];
    else return 64'd0;
    perim = 64'(2 * (x + hh + 2));
    w = 64'd1;
    for (int i = 0; i < shadow_alpha; i++) w = w * perim;
    return w;
  endfunction

  // Sum of candidate weights left of column col
  function automatic logic [63:0] weight_below(int col);
    logic [63:0] acc;
    acc = 64'd0;
    for (int x = 0; x < col; x++) acc += column_weight(x);
    return acc;
  endfunction

  function automatic void shadow_clear();
    for (int i = 0; i < ydw_pkg::MAX_COLUMNS; i++) shadow_heights[i] = '0;
    shadow_heights[0] = 1;
    shadow_used = 1;
  endfunction

  // Apply one word to the shadow diagram and return the expected result
  function automatic ydw_pkg::res_t predict_growth(ydw_pkg::cmd_t c);
    ydw_pkg::res_t r;
    logic [63:0]   total;
    logic [63:0]   target;
    logic [63:0]   run;
    int            chosen;
    logic          sat;
    if (c.action == ydw_pkg::ACT_CLEAR) begin
      shadow_clear();
      r.chosen_column = '0;
      r.column_count  = 9'd1;
      r.saturated     = 1'b0;
      return r;
    end
    total = weight_below(shadow_used + 1);
    target = c.random_word % total;
    chosen = shadow_used;
    run = 64'd0;
    for (int x = 0; x <= shadow_used; x++) begin
      run += column_weight(x);
      if (run > target) begin
        chosen = x;
        break;
      end
    end
    sat = 1'b0;
    if (chosen >= shadow_used) begin
      if (shadow_used >= ydw_pkg::MAX_COLUMNS) sat = 1'b1;
      else begin
        shadow_heights[shadow_used] = 1;
        shadow_used++;
      end
    end else if (shadow_heights[chosen] >= ydw_pkg::HEIGHT_MAX) begin
      sat = 1'b1;
    end else begin
      shadow_heights[chosen]++;
    end
    r.chosen_column = ydw_pkg::OUT_W'(chosen);
    r.column_count  = ydw_pkg::OUT_W'(shadow_used);
    r.saturated     = sat;
    return r;
  endfunction

  // Check each result word against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: actual %p", $time, res_o);
        error_count++;
      end else begin
        ydw_pkg::res_t exp_res;
        exp_res = pending_results.pop_front();
        if (res_o.chosen_column !== exp_res.chosen_column) begin
          $display("%0t chosen_column: expected %0d actual %0d", $time,
                   exp_res.chosen_column, res_o.chosen_column);
          error_count++;
        end
        if (res_o.column_count !== exp_res.column_count) begin
          $display("%0t column_count: expected %0d actual %0d", $time,
                   exp_res.column_count, res_o.column_count);
          error_count++;
        end
        if (res_o.saturated !== exp_res.saturated) begin
          $display("%0t saturated: expected %0d actual %0d", $time,
                   exp_res.saturated, res_o.saturated);
          error_count++;
        end
      end
    end
  end

  // Send one word; start stays high so a following word goes back to back
  task automatic send_word(logic act, logic [63:0] rnd);
    ydw_pkg::cmd_t c;
    ydw_pkg::res_t r;
    c.action = act;
    c.random_word = rnd;
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    r = predict_growth(c);
    if (r.saturated) sat_count++;
    pending_results = {pending_results, r};
    word_count++;
  endtask

  // Drop start and hold off for a number of cycles
  task automatic hold_off(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Random gap after a word, as the current idling phase asks
  task automatic sender_gap();
    if ($urandom_range(99) < idle_pct) begin
      if ($urandom_range(19) == 0) hold_off($urandom_range(1, 900));
      else hold_off($urandom_range(1, 40));
    end
  endtask

  // Grow the given column by aiming the target at its weight band
  task automatic grow_column(int col);
    send_word(ydw_pkg::ACT_GROW, weight_below(col));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_alpha(logic [ydw_pkg::ALPHA_W-1:0] a);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= a;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_alpha = a;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [63:0] random_word();
    case ($urandom_range(7))
      0:       return 64'd0;
      1:       return '1;
      2:       return 64'($urandom_range(255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Reset alpha, extremes of the random word and clear
  task automatic test_reset_state();
    send_word(ydw_pkg::ACT_GROW, 64'd0);
    send_word(ydw_pkg::ACT_GROW, '1);
    send_word(ydw_pkg::ACT_CLEAR, '1);
    send_word(ydw_pkg::ACT_CLEAR, 64'd0);
    send_word(ydw_pkg::ACT_GROW, 64'h8000_0000_0000_0000);
    hold_off(3);
    send_word(ydw_pkg::ACT_CLEAR, 64'h5555_5555_5555_5555);
    drain();
  endtask

  // For each alpha value, pick column zero, an inner column and the new column in turn
  task automatic test_candidates();
    for (int a = 0; a < 4; a++) begin
      write_alpha(ydw_pkg::ALPHA_W'(a));
      send_word(ydw_pkg::ACT_CLEAR, 64'd0);
      grow_column(1);
      grow_column(2);
      grow_column(0);
      grow_column(1);
      grow_column(3);
      send_word(ydw_pkg::ACT_GROW, weight_below(shadow_used + 1) - 1);
    end
    drain();
  endtask

  // Fill the column store, then ask for one more column
  task automatic test_column_full();
    write_alpha(ydw_pkg::ALPHA_W'(2));
    send_word(ydw_pkg::ACT_CLEAR, 64'd0);
    while (shadow_used < ydw_pkg::MAX_COLUMNS) grow_column(shadow_used);
    grow_column(shadow_used);
    grow_column(shadow_used);
    grow_column(0);
    send_word(ydw_pkg::ACT_GROW, {$urandom, $urandom});
    send_word(ydw_pkg::ACT_CLEAR, '1);
    drain();
  endtask

  // Grow column zero to the height limit and one past it
  task automatic test_height_limit();
    write_alpha(ydw_pkg::ALPHA_W'(0));
    send_word(ydw_pkg::ACT_CLEAR, 64'd0);
    while (shadow_heights[0] < ydw_pkg::HEIGHT_MAX) grow_column(0);
    grow_column(0);
    grow_column(1);
    send_word(ydw_pkg::ACT_CLEAR, 64'd0);
    drain();
  endtask

  // Random words in three idling phases and a short final run, mostly grows with rare clears
  task automatic test_random();
    logic [ydw_pkg::ALPHA_W-1:0] alphas [3];
    int                          pcts [3];
    alphas = '{ydw_pkg::ALPHA_W'(3), ydw_pkg::ALPHA_W'(1), ydw_pkg::ALPHA_W'(0)};
    pcts   = '{34, 73, 0};
    for (int ph = 0; ph < 3; ph++) begin
      write_alpha(alphas[ph]);
      idle_pct = pcts[ph];
      for (int n = 0; n < 334; n++) begin
        if ($urandom_range(39) == 0) send_word(ydw_pkg::ACT_CLEAR, random_word());
        else send_word(ydw_pkg::ACT_GROW, random_word());
        if (n == 100) drain();
        else sender_gap();
      end
    end
    write_alpha(ydw_pkg::ALPHA_W'(2));
    idle_pct = 20;
    for (int n = 0; n < 40; n++) begin
      send_word(ydw_pkg::ACT_GROW, random_word());
      sender_gap();
    end
    drain();
  endtask

  initial begin
    error_count = 0;
    cycle_count = 0;
    word_count  = 0;
    sat_count   = 0;
    idle_pct    = 0;
    shadow_clear();
    shadow_alpha = ydw_pkg::ALPHA_W'(1);
    start       = 1'b0;
    cmd_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_candidates();
    test_column_full();
    test_height_limit();
    test_random();

    drain();
    repeat (900) @(posedge clk_i);
    $display("Sent %0d words over all alpha values, %0d of them saturated,", word_count,
             sat_count);
    $display("including a full column store and a column at its height limit.");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("young_diagram_weighted_growth_test: clean");
    end else begin
      $display("young_diagram_weighted_growth_test: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/ydw_pkg.sv
rtl/core/ydw_cell.sv
rtl/core/ydw_weight.sv
rtl/core/ydw_modulo.sv
rtl/core/young_diagram_weighted_growth.sv
bench/young_diagram_weighted_growth_test.sv
